[rtl/srsr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsr_pkg
// Shared widths, status codes and saturating Q16.16 helpers.
// ----------------------------------------------------------------------------
package srsr_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int IDX_BITS  = 31;
    localparam int STAT_BITS = 2;

    typedef logic signed [WORD_BITS-1:0] word_t;

    typedef enum logic [STAT_BITS-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_TIR  = 2'd2
    } status_t;

    localparam word_t WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam word_t WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam word_t ONE  = word_t'(64'sd1 <<< FRAC_BITS);

    function automatic word_t sat(input logic signed [WORD_BITS+1:0] v);
        if (v > $signed({2'b00, WMAX}))
            return WMAX;
        else if (v < $signed({2'b11, WMIN}))
            return WMIN;
        return v[WORD_BITS-1:0];
    endfunction

    function automatic word_t f_add(input word_t a, input word_t b);
        return sat({{2{a[WORD_BITS-1]}}, a} + {{2{b[WORD_BITS-1]}}, b});
    endfunction

    function automatic word_t f_sub(input word_t a, input word_t b);
        return sat({{2{a[WORD_BITS-1]}}, a} - {{2{b[WORD_BITS-1]}}, b});
    endfunction

    // sign-magnitude truncating product
    function automatic word_t f_mul(input word_t a, input word_t b);
        logic [WORD_BITS-1:0]   ma;
        logic [WORD_BITS-1:0]   mb;
        logic [2*WORD_BITS-1:0] p;
        logic [2*WORD_BITS-1:0] m;
        logic                   neg;
        ma  = a[WORD_BITS-1] ? WORD_BITS'(-a) : WORD_BITS'(a);
        mb  = b[WORD_BITS-1] ? WORD_BITS'(-b) : WORD_BITS'(b);
        neg = a[WORD_BITS-1] ^ b[WORD_BITS-1];
        p   = ma * mb;
        m   = p >> FRAC_BITS;
        if (!neg)
            return (m > 64'(WMAX)) ? WMAX : word_t'(m[WORD_BITS-1:0]);
        if (m > 64'(WMAX) + 64'd1)
            return WMIN;
        return word_t'(-m[WORD_BITS-1:0]);
    endfunction

endpackage

[rtl/skew_ray_surface_refraction_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skew_ray_surface_refraction_unit
// Skew-ray intersection and refraction at one spherical or plane surface.
// ----------------------------------------------------------------------------
// One request enters every cycle while busy is low; busy stays low, as the
// pipeline has no back-pressure. Each request yields one result with done
// high for one cycle, in request order.
// The pipeline depth is set by the two 24-stage square roots and the
// 48-stage divider, each built as a chain of one-bit stages, plus 18
// stages of products and sums; the receiver cannot stall.
module skew_ray_surface_refraction_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [31:0]                pos_x,
    input  logic signed [31:0]                pos_y,
    input  logic signed [31:0]                pos_z,
    input  logic signed [31:0]                axial_gap,
    input  logic signed [31:0]                dir_x,
    input  logic signed [31:0]                dir_y,
    input  logic signed [31:0]                dir_z,
    input  logic [srsr_pkg::IDX_BITS-1:0]     index_before,
    input  logic signed [31:0]                curvature,
    input  logic [srsr_pkg::IDX_BITS-1:0]     index_after,
    output logic                              done,
    output logic signed [31:0]                hit_x,
    output logic signed [31:0]                hit_y,
    output logic signed [31:0]                hit_z,
    output logic signed [31:0]                new_dir_x,
    output logic signed [31:0]                new_dir_y,
    output logic signed [31:0]                new_dir_z,
    output logic signed [31:0]                path_length,
    output logic signed [31:0]                cos_incidence,
    output logic signed [31:0]                cos_refraction,
    output logic [srsr_pkg::STAT_BITS-1:0]    status
);

    localparam int W   = srsr_pkg::WORD_BITS;
    localparam int F   = srsr_pkg::FRAC_BITS;
    localparam int SQB = (W + F) / 2;
    localparam int QB  = W + F;
    localparam int S1  = 8;
    localparam int SQ0 = S1 + 1;
    localparam int SQ1 = SQ0 + SQB;
    localparam int DV1 = SQ1 + 1 + QB;
    localparam int S2  = DV1 + 1;
    localparam int SQ2 = S2 + 4;
    localparam int SQ3 = SQ2 + SQB;
    localparam int NS  = SQ3 + 3;

    typedef struct packed {
        srsr_pkg::word_t px, py, pz;
        srsr_pkg::word_t dx, dy, dz;
        srsr_pkg::word_t n1, n2, c;
        srsr_pkg::word_t a, b, cc, disc, s, den;
        srsr_pkg::word_t t, nx, ny, nz, ci, rt, cr, k;
        srsr_pkg::word_t ndx, ndy, ndz;
        srsr_pkg::word_t e0, e1, e2;
        logic [W-1:0]    sq_rem;
        logic [W-1:0]    sq_y;
        logic [QB:0]     dv_r;
        logic [QB-1:0]   dv_n;
        logic [QB-1:0]   dv_q;
        logic [W-1:0]    dv_d;
        logic            dv_neg;
        logic            dv_zero;
        logic            dv_sat;
        srsr_pkg::status_t st;
    } stage_t;

    stage_t          st_reg   [NS];
    stage_t          st_next  [NS];
    logic   [NS-1:0] vld_reg;

    logic [2*SQB-1:0] sq_x_reg [NS];
    logic [2*SQB-1:0] sq_x_next [NS];

    assign busy = 1'b0;

    function automatic srsr_pkg::word_t in32(input logic signed [31:0] v);
        return srsr_pkg::word_t'(v);
    endfunction

    always_comb
    begin
        stage_t s;
        stage_t p;
        logic [2*SQB-1:0] x;
        logic [W+1:0]     trial;
        logic [W+1:0]     rem2;
        logic [QB:0]      r2;
        logic [2*QB-1:0]  mn;
        logic [W-1:0]     mg;
        for (int i = 0; i < NS; i++)
        begin
            p = (i == 0) ? '0 : st_reg[i-1];
            s = p;
            x = (i == 0) ? '0 : sq_x_reg[i-1];
            trial = '0;
            rem2  = '0;
            r2    = '0;
            mn    = '0;
            mg    = '0;
            if (i == 0)
            begin
                s.px = in32(pos_x);
                s.py = in32(pos_y);
                s.pz = srsr_pkg::f_sub(in32(pos_z), in32(axial_gap));
                s.dx = in32(dir_x);
                s.dy = in32(dir_y);
                s.dz = in32(dir_z);
                s.n1 = srsr_pkg::word_t'({1'b0, index_before});
                s.n2 = srsr_pkg::word_t'({1'b0, index_after});
                s.c  = in32(curvature);
                s.st = srsr_pkg::ST_OK;
            end
            else if (i == 1)
            begin
                s.e0 = srsr_pkg::f_mul(p.dx, p.px);
                s.e1 = srsr_pkg::f_mul(p.dy, p.py);
                s.e2 = srsr_pkg::f_mul(p.dz, p.pz);
                s.a  = srsr_pkg::f_mul(p.c, p.n1);
            end
            else if (i == 2)
            begin
                s.b  = srsr_pkg::f_add(srsr_pkg::f_add(p.e0, p.e1), p.e2);
                s.e0 = srsr_pkg::f_mul(p.px, p.px);
                s.e1 = srsr_pkg::f_mul(p.py, p.py);
                s.e2 = srsr_pkg::f_mul(p.pz, p.pz);
                s.a  = srsr_pkg::f_mul(p.a, p.n1);
            end
            else if (i == 3)
            begin
                s.b  = srsr_pkg::f_mul(p.c, p.b);
                s.cc = srsr_pkg::f_add(srsr_pkg::f_add(p.e0, p.e1), p.e2);
            end
            else if (i == 4)
            begin
                s.b  = srsr_pkg::f_sub(p.dz, p.b);
                s.cc = srsr_pkg::f_mul(p.c, p.cc);
            end
            else if (i == 5)
            begin
                s.cc = srsr_pkg::f_sub(p.cc, srsr_pkg::f_add(p.pz, p.pz));
                s.e0 = srsr_pkg::f_mul(p.b, p.b);
            end
            else if (i == 6)
            begin
                s.e1 = srsr_pkg::f_mul(p.a, p.cc);
            end
            else if (i == 7)
            begin
                s.disc = srsr_pkg::f_sub(p.e0, p.e1);
            end
            else if (i == S1)
            begin
                if (p.c != '0)
                begin
                    if (p.disc[W-1])
                        s.st = srsr_pkg::ST_MISS;
                end
                else if (p.dz == '0)
                    s.st = srsr_pkg::ST_MISS;
                s.sq_y   = '0;
                s.sq_rem = '0;
            end
            else if ((i >= SQ0 && i < SQ1) || (i >= SQ2 && i < SQ3))
            begin
                // one result bit per stage, restoring root
                if (i == SQ0 || i == SQ2)
                begin
                    x = (i == SQ0)
                        ? ((p.disc[W-1] || p.disc == '0) ? '0
                           : (2*SQB)'({p.disc, {F{1'b0}}}))
                        : ((p.rt[W-1] || p.rt == '0) ? '0
                           : (2*SQB)'({p.rt, {F{1'b0}}}));
                    s.sq_y   = '0;
                    s.sq_rem = '0;
                end
                rem2  = {s.sq_rem, x[2*SQB-1:2*SQB-2]};
                trial = {s.sq_y, 2'b01};
                if (rem2 >= trial)
                begin
                    s.sq_rem = W'(rem2 - trial);
                    s.sq_y   = {s.sq_y[W-2:0], 1'b1};
                end
                else
                begin
                    s.sq_rem = W'(rem2);
                    s.sq_y   = {s.sq_y[W-2:0], 1'b0};
                end
                x = {x[2*SQB-3:0], 2'b00};
                if (i == SQ1 - 1)
                    s.s = srsr_pkg::word_t'(s.sq_y);
                if (i == SQ3 - 1)
                begin
                    s.rt = srsr_pkg::word_t'(s.sq_y);
                    s.cr = p.ci[W-1] || p.ci == '0
                        ? srsr_pkg::f_sub('0, srsr_pkg::word_t'(s.sq_y))
                        : srsr_pkg::word_t'(s.sq_y);
                end
            end
            else if (i == SQ1)
            begin
                s.den = (p.b > 0) ? srsr_pkg::f_add(p.b, p.s) : srsr_pkg::f_sub(p.b, p.s);
                s.dv_zero = 1'b0;
                s.dv_sat  = 1'b0;
                if (p.c != '0)
                begin
                    s.e0 = p.cc;
                    if (s.den == '0)
                    begin
                        s.dv_zero = 1'b1;
                        if (p.cc != '0 && p.st == srsr_pkg::ST_OK)
                            s.st = srsr_pkg::ST_MISS;
                    end
                end
                else
                begin
                    s.e0  = srsr_pkg::f_sub('0, p.pz);
                    s.den = p.dz;
                end
                mg = s.e0[W-1] ? W'(-s.e0) : W'(s.e0);
                mn = (2*QB)'(mg) << F;
                s.dv_n   = QB'(mn);
                s.dv_d   = s.den[W-1] ? W'(-s.den) : W'(s.den);
                s.dv_neg = s.e0[W-1] ^ s.den[W-1];
                s.dv_r   = '0;
                s.dv_q   = '0;
            end
            else if (i > SQ1 && i <= SQ1 + QB)
            begin
                r2 = {s.dv_r[QB-1:0], s.dv_n[QB-1]};
                s.dv_n = {s.dv_n[QB-2:0], 1'b0};
                if (r2 >= (QB+1)'(s.dv_d))
                begin
                    s.dv_r = r2 - (QB+1)'(s.dv_d);
                    s.dv_q = {s.dv_q[QB-2:0], 1'b1};
                end
                else
                begin
                    s.dv_r = r2;
                    s.dv_q = {s.dv_q[QB-2:0], 1'b0};
                end
            end
            else if (i == DV1)
            begin
                if (p.st != srsr_pkg::ST_OK || p.dv_zero)
                    s.t = '0;
                else if (p.dv_d == '0)
                    s.t = (p.e0 == '0) ? '0 : (p.e0[W-1] ? srsr_pkg::WMIN : srsr_pkg::WMAX);
                else if (!p.dv_neg)
                    s.t = (p.dv_q > QB'(srsr_pkg::WMAX)) ? srsr_pkg::WMAX
                          : srsr_pkg::word_t'(p.dv_q[W-1:0]);
                else
                    s.t = (p.dv_q > QB'(srsr_pkg::WMAX) + QB'(1)) ? srsr_pkg::WMIN
                          : srsr_pkg::word_t'(-p.dv_q[W-1:0]);
                s.e0 = srsr_pkg::f_mul(s.t, p.dx);
                s.e1 = srsr_pkg::f_mul(s.t, p.dy);
                s.e2 = srsr_pkg::f_mul(s.t, p.dz);
            end
            else if (i == S2)
            begin
                if (p.st == srsr_pkg::ST_OK)
                begin
                    s.px = srsr_pkg::f_add(p.px, p.e0);
                    s.py = srsr_pkg::f_add(p.py, p.e1);
                    s.pz = srsr_pkg::f_add(p.pz, p.e2);
                end
                s.nx = srsr_pkg::f_mul(p.c, s.px);
                s.ny = srsr_pkg::f_mul(p.c, s.py);
                s.nz = srsr_pkg::f_mul(p.c, s.pz);
            end
            else if (i == S2 + 1)
            begin
                s.nx = srsr_pkg::f_sub('0, p.nx);
                s.ny = srsr_pkg::f_sub('0, p.ny);
                s.nz = srsr_pkg::f_add(srsr_pkg::ONE, srsr_pkg::f_sub('0, p.nz));
                s.e0 = srsr_pkg::f_mul(p.dx, s.nx);
                s.e1 = srsr_pkg::f_mul(p.dy, s.ny);
                s.e2 = srsr_pkg::f_mul(p.dz, s.nz);
            end
            else if (i == S2 + 2)
            begin
                s.ci = srsr_pkg::f_add(srsr_pkg::f_add(p.e0, p.e1), p.e2);
                s.e0 = srsr_pkg::f_mul(s.ci, s.ci);
                s.e1 = srsr_pkg::f_mul(srsr_pkg::f_add(p.n2, p.n1),
                                       srsr_pkg::f_sub(p.n2, p.n1));
            end
            else if (i == S2 + 3)
            begin
                s.rt = srsr_pkg::f_add(p.e0, p.e1);
                if (p.st == srsr_pkg::ST_OK && s.rt[W-1])
                    s.st = srsr_pkg::ST_TIR;
            end
            else if (i == SQ3)
            begin
                s.k  = srsr_pkg::f_sub(p.cr, p.ci);
                s.e0 = srsr_pkg::f_mul(s.k, p.nx);
                s.e1 = srsr_pkg::f_mul(s.k, p.ny);
                s.e2 = srsr_pkg::f_mul(s.k, p.nz);
            end
            else if (i == SQ3 + 1)
            begin
                s.ndx = srsr_pkg::f_add(p.dx, p.e0);
                s.ndy = srsr_pkg::f_add(p.dy, p.e1);
                s.ndz = srsr_pkg::f_add(p.dz, p.e2);
            end
            else
            begin
                if (p.st != srsr_pkg::ST_OK)
                begin
                    s.ndx = '0;
                    s.ndy = '0;
                    s.ndz = '0;
                    s.cr  = '0;
                end
                if (p.st == srsr_pkg::ST_MISS)
                begin
                    s.t  = '0;
                    s.ci = '0;
                end
            end
            st_next[i]   = s;
            sq_x_next[i] = x;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[NS-2:0], start};
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NS; i++)
        begin
            st_reg[i]   <= st_next[i];
            sq_x_reg[i] <= sq_x_next[i];
        end
    end

    assign done           = vld_reg[NS-1];
    assign hit_x          = st_reg[NS-1].px;
    assign hit_y          = st_reg[NS-1].py;
    assign hit_z          = st_reg[NS-1].pz;
    assign new_dir_x      = st_reg[NS-1].ndx;
    assign new_dir_y      = st_reg[NS-1].ndy;
    assign new_dir_z      = st_reg[NS-1].ndz;
    assign path_length    = st_reg[NS-1].t;
    assign cos_incidence  = st_reg[NS-1].ci;
    assign cos_refraction = st_reg[NS-1].cr;
    assign status         = st_reg[NS-1].st;

endmodule

[rtl/srsr_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsr_checker
// Port-level checks on the refraction unit's results.
// ----------------------------------------------------------------------------
module srsr_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           busy,
    input logic                           done,
    input logic [srsr_pkg::STAT_BITS-1:0] status,
    input logic [31:0]                    new_dir_x,
    input logic [31:0]                    path_length,
    input logic [31:0]                    cos_incidence,
    input logic [31:0]                    cos_refraction
);

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == srsr_pkg::ST_OK || status == srsr_pkg::ST_MISS ||
                  status == srsr_pkg::ST_TIR))
        else $error("bad status");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == srsr_pkg::ST_MISS) |->
            (path_length == '0 && cos_incidence == '0))
        else $error("miss carries data");

    a_fail_dir: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != srsr_pkg::ST_OK) |->
            (new_dir_x == '0 && cos_refraction == '0))
        else $error("refracted data on failure");

endmodule

bind skew_ray_surface_refraction_unit srsr_checker u_srsr_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .busy           (busy),
    .done           (done),
    .status         (status),
    .new_dir_x      (new_dir_x),
    .path_length    (path_length),
    .cos_incidence  (cos_incidence),
    .cos_refraction (cos_refraction)
);
